// ----- src/arrt_pkg.sv -----
`timescale 1ns / 1ps

package arrt_pkg;

    // Operation codes
    localparam logic [2:0] OP_REGISTER    = 3'd0;
    localparam logic [2:0] OP_UNREGISTER  = 3'd1;
    localparam logic [2:0] OP_UNREG_RANGE = 3'd2;
    localparam logic [2:0] OP_CLEAR       = 3'd3;
    localparam logic [2:0] OP_RESOLVE     = 3'd4;
    localparam logic [2:0] OP_COUNT       = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam int ADDR_W  = 64;
    localparam int KIND_W  = 2;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 7;

    // One table entry as stored in the memory
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
    } entry_t;

endpackage

// ----- src/address_range_resolver_table_unit.sv -----
`timescale 1ns / 1ps
// Count, no-op opcodes and register with a zero start or size go straight to the result;
// unregister, range removal, clear and resolve scan the table through the single read port;
// a scanning register then also passes through the write-back state.
// Throughput: one operation at a time; the next input beat is taken once the result is in
// the output register, which may still be waiting on out_ready.
// Reset: control state clears, then a sweep invalidates every entry (no input).
module address_range_resolver_table_unit
    import arrt_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic [ADDR_W-1:0]  address,
    input  logic [ADDR_W-1:0]  range_size,
    input  logic [KIND_W-1:0]  kind,
    input  logic [TAG_W-1:0]   tag,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [ADDR_W-1:0]  hit_start,
    output logic [ADDR_W-1:0]  hit_size,
    output logic [ADDR_W-1:0]  hit_offset,
    output logic [KIND_W-1:0]  hit_kind,
    output logic [TAG_W-1:0]   hit_tag,
    output logic [COUNT_W-1:0] entry_count
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int ISS_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [ISS_W-1:0] ISS_END  = ISS_W'(ENTRIES);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_DONE
    } state_t;

    state_t state_reg;

    // Latched operation
    logic [2:0]        op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [ADDR_W-1:0] range_end_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [1:0]        status_reg;

    // Scan pointers
    logic [ISS_W-1:0]  issue_cnt_reg;
    logic              pipe_vld_reg;
    logic [IDX_W-1:0]  pipe_idx_reg;
    logic [CNT_W-1:0]  count_reg;

    // Register search
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    // Resolve best candidate
    logic              best_found_reg;
    logic [ADDR_W-1:0] best_start_reg;
    logic [ADDR_W-1:0] best_len_reg;
    logic [KIND_W-1:0] best_kind_reg;
    logic [TAG_W-1:0]  best_tag_reg;

    // Output register
    logic               out_valid_reg;
    logic [1:0]         status_out_reg;
    logic [ADDR_W-1:0]  hit_start_reg;
    logic [ADDR_W-1:0]  hit_size_reg;
    logic [ADDR_W-1:0]  hit_offset_reg;
    logic [KIND_W-1:0]  hit_kind_reg;
    logic [TAG_W-1:0]   hit_tag_reg;
    logic [COUNT_W-1:0] entry_count_reg;

    // Entry memory
    entry_t            mem [ENTRIES];
    entry_t            rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;

    logic              issuing;
    logic              last_proc;
    logic [ADDR_W-1:0] cur_end;
    logic              cur_hit;
    logic              cur_better;
    logic              kill_cond;
    logic              kill_now;
    logic              accept;
    logic              out_free;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    assign rd_addr   = issue_cnt_reg[IDX_W-1:0];
    assign issuing   = (state_reg == S_SCAN) && (issue_cnt_reg < ISS_END);
    assign last_proc = pipe_vld_reg && (pipe_idx_reg == LAST_IDX);

    // Per-entry evaluation of the entry read last cycle
    assign cur_end = rd_data_reg.start + rd_data_reg.length;
    assign cur_hit = rd_data_reg.valid && (addr_reg >= rd_data_reg.start)
                     && (addr_reg < cur_end);
    assign cur_better = !best_found_reg || (rd_data_reg.length < best_len_reg)
                        || ((rd_data_reg.length == best_len_reg)
                            && (rd_data_reg.start > best_start_reg));

    always_comb
    begin
        unique case (op_reg)
            OP_UNREGISTER:  kill_cond = (rd_data_reg.start == addr_reg);
            OP_UNREG_RANGE: kill_cond = (rd_data_reg.start >= addr_reg)
                                        && (rd_data_reg.start < range_end_reg);
            OP_CLEAR:       kill_cond = 1'b1;
            default:        kill_cond = 1'b0;
        endcase
    end

    assign kill_now = (state_reg == S_SCAN) && pipe_vld_reg && rd_data_reg.valid
                      && kill_cond;

    // Memory write port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pipe_idx_reg;
        mem_wdata = rd_data_reg;
        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = rd_addr;
                mem_wdata = '0;
            end
            S_SCAN:
            begin
                mem_we          = kill_now;
                mem_wdata.valid = 1'b0;
            end
            S_COMMIT:
            begin
                mem_we    = match_found_reg || free_found_reg;
                mem_waddr = match_found_reg ? match_idx_reg : free_idx_reg;
                mem_wdata = '{valid: 1'b1, start: addr_reg, length: len_reg,
                              kind: kind_reg, tag: tag_reg};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    // Control, scan trackers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            op_reg          <= OP_COUNT;
            addr_reg        <= '0;
            len_reg         <= '0;
            range_end_reg   <= '0;
            kind_reg        <= '0;
            tag_reg         <= '0;
            status_reg      <= ST_OK;
            issue_cnt_reg   <= '0;
            pipe_vld_reg    <= 1'b0;
            pipe_idx_reg    <= '0;
            count_reg       <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            best_found_reg  <= 1'b0;
            best_start_reg  <= '0;
            best_len_reg    <= '0;
            best_kind_reg   <= '0;
            best_tag_reg    <= '0;
            out_valid_reg   <= 1'b0;
            status_out_reg  <= ST_OK;
            hit_start_reg   <= '0;
            hit_size_reg    <= '0;
            hit_offset_reg  <= '0;
            hit_kind_reg    <= '0;
            hit_tag_reg     <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            // The hand-over state sets valid itself
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            pipe_vld_reg <= issuing;
            pipe_idx_reg <= rd_addr;

            unique case (state_reg)
                // Post-reset sweep invalidating every entry
                S_INIT:
                begin
                    if (rd_addr == LAST_IDX)
                    begin
                        state_reg     <= S_IDLE;
                        issue_cnt_reg <= '0;
                    end
                    else
                    begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                end

                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg          <= opcode;
                        addr_reg        <= address;
                        len_reg         <= range_size;
                        range_end_reg   <= address + range_size;
                        kind_reg        <= kind;
                        tag_reg         <= tag;
                        issue_cnt_reg   <= '0;
                        match_found_reg <= 1'b0;
                        free_found_reg  <= 1'b0;
                        best_found_reg  <= 1'b0;
                        if ((opcode == OP_REGISTER)
                            && ((address == '0) || (range_size == '0)))
                        begin
                            status_reg <= ST_IGNORED;
                            state_reg  <= S_DONE;
                        end
                        else if ((opcode == OP_REGISTER) || (opcode == OP_UNREGISTER)
                                 || (opcode == OP_UNREG_RANGE) || (opcode == OP_CLEAR)
                                 || (opcode == OP_RESOLVE))
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_SCAN;
                        end
                        else
                        begin
                            status_reg <= ST_OK;
                            state_reg  <= S_DONE;
                        end
                    end
                end

                // One entry read per cycle, evaluated in the following cycle
                S_SCAN:
                begin
                    if (issuing)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                    if (pipe_vld_reg)
                    begin
                        if (rd_data_reg.valid && (rd_data_reg.start == addr_reg)
                            && !match_found_reg)
                        begin
                            match_found_reg <= 1'b1;
                            match_idx_reg   <= pipe_idx_reg;
                        end
                        if (!rd_data_reg.valid && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= pipe_idx_reg;
                        end
                        if (cur_hit && cur_better)
                        begin
                            best_found_reg <= 1'b1;
                            best_start_reg <= rd_data_reg.start;
                            best_len_reg   <= rd_data_reg.length;
                            best_kind_reg  <= rd_data_reg.kind;
                            best_tag_reg   <= rd_data_reg.tag;
                        end
                    end
                    if (kill_now)
                    begin
                        count_reg <= count_reg - 1'b1;
                    end
                    if (last_proc)
                    begin
                        state_reg <= (op_reg == OP_REGISTER) ? S_COMMIT : S_DONE;
                    end
                end

                // Register write-back: replace, insert or report full
                S_COMMIT:
                begin
                    if (!match_found_reg && free_found_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else if (!match_found_reg)
                    begin
                        status_reg <= ST_FULL;
                    end
                    state_reg <= S_DONE;
                end

                // Hand the result to the output register
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        entry_count_reg <= COUNT_W'(count_reg);
                        if ((op_reg == OP_RESOLVE) && best_found_reg)
                        begin
                            status_out_reg <= status_reg;
                            hit_start_reg  <= best_start_reg;
                            hit_size_reg   <= best_len_reg;
                            hit_offset_reg <= addr_reg - best_start_reg;
                            hit_kind_reg   <= best_kind_reg;
                            hit_tag_reg    <= best_tag_reg;
                        end
                        else
                        begin
                            status_out_reg <= (op_reg == OP_RESOLVE) ? ST_NOT_FOUND
                                                                     : status_reg;
                            hit_start_reg  <= '0;
                            hit_size_reg   <= '0;
                            hit_offset_reg <= '0;
                            hit_kind_reg   <= '0;
                            hit_tag_reg    <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_out_reg;
    assign hit_start   = hit_start_reg;
    assign hit_size    = hit_size_reg;
    assign hit_offset  = hit_offset_reg;
    assign hit_kind    = hit_kind_reg;
    assign hit_tag     = hit_tag_reg;
    assign entry_count = entry_count_reg;

    // Entry count never exceeds the table depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count above table depth");

    // A scan write-back never hits the entry being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && mem_we && issuing |-> mem_waddr != rd_addr)
        else $error("scan write collides with read");

    // An accepted beat closes the input until its result is handed over
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input reopened before result");

    // A new result appears only out of the hand-over state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside hand-over");

    // The write-back state is only entered by a register operation
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> (op_reg == OP_REGISTER))
        else $error("commit for non-register operation");

endmodule

// ----- tb/range_table_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the range table and checks
// every result beat against the oldest predicted result.
module range_table_checker
    import arrt_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [2:0]         opcode,
    input  logic [ADDR_W-1:0]  address,
    input  logic [ADDR_W-1:0]  range_size,
    input  logic [KIND_W-1:0]  kind,
    input  logic [TAG_W-1:0]   tag,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         status,
    input  logic [ADDR_W-1:0]  hit_start,
    input  logic [ADDR_W-1:0]  hit_size,
    input  logic [ADDR_W-1:0]  hit_offset,
    input  logic [KIND_W-1:0]  hit_kind,
    input  logic [TAG_W-1:0]   hit_tag,
    input  logic [COUNT_W-1:0] entry_count,
    output int                 mismatch_count,
    output int                 results_owed
);

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  start;
        logic [ADDR_W-1:0]  size;
        logic [ADDR_W-1:0]  offset;
        logic [KIND_W-1:0]  kind;
        logic [TAG_W-1:0]   tag;
        logic [COUNT_W-1:0] count;
    } table_result_t;

    // Shadow table
    bit                tbl_valid [ENTRIES];
    logic [ADDR_W-1:0] tbl_start [ENTRIES];
    logic [ADDR_W-1:0] tbl_len   [ENTRIES];
    logic [KIND_W-1:0] tbl_kind  [ENTRIES];
    logic [TAG_W-1:0]  tbl_tag   [ENTRIES];

    table_result_t expected_results [$];
    table_result_t oldest;

    // Apply one operation to the shadow table and return the result it yields
    function automatic table_result_t apply_table_op(
        input logic [2:0]        op,
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] size,
        input logic [KIND_W-1:0] knd,
        input logic [TAG_W-1:0]  tg
    );
        table_result_t     r;
        int                slot;
        int                best;
        int                used;
        logic [ADDR_W-1:0] span_end;
        r    = '0;
        slot = -1;
        best = -1;
        used = 0;
        case (op)
            OP_REGISTER:
                if (addr == '0 || size == '0) begin
                    r.status = ST_IGNORED;
                end else begin
                    // same start is replaced, else the first free slot
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && tbl_valid[i] && tbl_start[i] == addr)
                            slot = i;
                    for (int i = 0; i < ENTRIES; i++)
                        if (slot < 0 && !tbl_valid[i])
                            slot = i;
                    if (slot < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        tbl_valid[slot] = 1'b1;
                        tbl_start[slot] = addr;
                        tbl_len[slot]   = size;
                        tbl_kind[slot]  = knd;
                        tbl_tag[slot]   = tg;
                    end
                end
            OP_UNREGISTER:
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_start[i] == addr)
                        tbl_valid[i] = 1'b0;
            OP_UNREG_RANGE: begin
                // a wrapped end leaves the window empty
                span_end = addr + size;
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i] && tbl_start[i] >= addr && tbl_start[i] < span_end)
                        tbl_valid[i] = 1'b0;
            end
            OP_CLEAR:
                for (int i = 0; i < ENTRIES; i++)
                    tbl_valid[i] = 1'b0;
            OP_RESOLVE: begin
                // smallest containing range, higher start on a size tie
                for (int i = 0; i < ENTRIES; i++) begin
                    span_end = tbl_start[i] + tbl_len[i];
                    if (tbl_valid[i] && addr >= tbl_start[i] && addr < span_end) begin
                        if (best < 0 || tbl_len[i] < tbl_len[best] ||
                            (tbl_len[i] == tbl_len[best] && tbl_start[i] > tbl_start[best]))
                            best = i;
                    end
                end
                if (best < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.start  = tbl_start[best];
                    r.size   = tbl_len[best];
                    r.offset = addr - tbl_start[best];
                    r.kind   = tbl_kind[best];
                    r.tag    = tbl_tag[best];
                end
            end
            default: ;
        endcase
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i])
                used++;
        r.count = used[COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(
        input string             field,
        input logic [ADDR_W-1:0] want,
        input logic [ADDR_W-1:0] got
    );
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    assign results_owed = expected_results.size();

    // Result beats are checked before the input beat of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < ENTRIES; i++)
                tbl_valid[i] = 1'b0;
            expected_results.delete();
            mismatch_count = 0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result beat with no result expected", $time);
                    mismatch_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("status", oldest.status, status);
                    check_field("hit_start", oldest.start, hit_start);
                    check_field("hit_size", oldest.size, hit_size);
                    check_field("hit_offset", oldest.offset, hit_offset);
                    check_field("hit_kind", oldest.kind, hit_kind);
                    check_field("hit_tag", oldest.tag, hit_tag);
                    check_field("entry_count", oldest.count, entry_count);
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_table_op(opcode, address, range_size,
                                                          kind, tag));
        end
    end

endmodule

// ----- tb/tb_address_range_resolver_table_unit.sv -----
`timescale 1ns / 1ps

module tb_address_range_resolver_table_unit;
    import arrt_pkg::*;

    localparam int ENTRIES      = 64;
    localparam int RANDOM_ITEMS = 950;
    localparam int PHASE_LEN    = 100;

    // opcodes the block treats as no-ops
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam logic [KIND_W-1:0] KIND_BUFFER   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_IMAGE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GPU_HEAP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BINDLESS = 2'd3;

    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [2:0]         opcode      = OP_COUNT;
    logic [ADDR_W-1:0]  address     = '0;
    logic [ADDR_W-1:0]  range_size  = '0;
    logic [KIND_W-1:0]  kind        = '0;
    logic [TAG_W-1:0]   tag         = '0;
    logic               out_valid;
    logic               out_ready   = 1'b1;
    logic [1:0]         status;
    logic [ADDR_W-1:0]  hit_start;
    logic [ADDR_W-1:0]  hit_size;
    logic [ADDR_W-1:0]  hit_offset;
    logic [KIND_W-1:0]  hit_kind;
    logic [TAG_W-1:0]   hit_tag;
    logic [COUNT_W-1:0] entry_count;
    int                 mismatch_count;
    int                 results_owed;

    // starts registered lately, so removals and lookups tend to hit
    logic [ADDR_W-1:0]  recent_starts [16];

    address_range_resolver_table_unit #(.ENTRIES(ENTRIES)) dut (.*);

    range_table_checker #(.ENTRIES(ENTRIES)) result_checker (.*);

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #10_000_000;
        $display("address_range_resolver_table_unit test failed");
        $finish;
    end

    // Result side: short ready toggling, long open stretches, a few long stalls
    initial
    begin
        int  r;
        int  hold;
        logic level;
        @(posedge rst_n);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                level = 1'b1;
                hold  = $urandom_range(1, 4);
            end else if (r < 85) begin
                level = 1'b0;
                hold  = $urandom_range(1, 3);
            end else if (r < 95) begin
                level = 1'b1;
                hold  = $urandom_range(30, 150);
            end else begin
                level = 1'b0;
                hold  = $urandom_range(10, 50);
            end
            out_ready <= level;
            repeat (hold) @(posedge clk);
        end
    end

    function automatic logic [ADDR_W-1:0] rand_wide();
        return {$urandom, $urandom};
    endfunction

    // Starts cluster around a few bases so entries collide and overlap
    function automatic logic [ADDR_W-1:0] pick_start();
        logic [ADDR_W-1:0] base;
        case ($urandom_range(0, 4))
            0: base = 64'h0000_0000_0001_0000;
            1: base = 64'h0000_7FF0_0000_0000;
            2: base = 64'h8000_0000_4000_0000;
            3: base = 64'hFFFF_FFFF_FFFF_0000;
            default: return rand_wide();
        endcase
        return base + ADDR_W'({$urandom_range(0, 255), 4'h0});
    endfunction

    function automatic logic [ADDR_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return '0;
        if (r < 43)
            case ($urandom_range(0, 2))
                0: return 64'h10;
                1: return 64'h100;
                default: return 64'h1000;
            endcase
        if (r < 88)
            return ADDR_W'($urandom_range(1, 8192));
        return rand_wide();
    endfunction

    function automatic logic [ADDR_W-1:0] recent_start();
        return recent_starts[4'($urandom_range(0, 15))];
    endfunction

    // Fill phases mostly register; mixed phases exercise everything
    function automatic logic [2:0] pick_op(input bit fill);
        int r;
        r = $urandom_range(0, 99);
        if (fill) begin
            if (r < 85) return OP_REGISTER;
            if (r < 95) return OP_RESOLVE;
            return OP_COUNT;
        end
        if (r < 35) return OP_REGISTER;
        if (r < 45) return OP_UNREGISTER;
        if (r < 51) return OP_UNREG_RANGE;
        if (r < 52) return OP_CLEAR;
        if (r < 90) return OP_RESOLVE;
        if (r < 95) return OP_COUNT;
        return ($urandom_range(0, 1) != 0) ? OP_SPARE_6 : OP_SPARE_7;
    endfunction

    // Drive one input beat and hold it until the block takes it
    task automatic send_op(
        input logic [2:0]        op,
        input logic [ADDR_W-1:0] addr,
        input logic [ADDR_W-1:0] size,
        input logic [KIND_W-1:0] knd,
        input logic [TAG_W-1:0]  tg
    );
        opcode     <= op;
        address    <= addr;
        range_size <= size;
        kind       <= knd;
        tag        <= tg;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        if (op == OP_REGISTER && addr != '0)
            recent_starts[4'($urandom_range(0, 15))] = addr;
    endtask

    task automatic idle_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 55)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stimulus
    initial
    begin
        bit                fill_phase;
        bit                idle_on;
        logic [2:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] size;
        int                r;

        for (int i = 0; i < 16; i++)
            recent_starts[i] = pick_start();
        fill_phase = 1'b0;
        idle_on    = 1'b1;

        do
            @(posedge clk);
        while (!rst_n);

        // Directed: empty table, zero inputs, tie, replace, wrapping ranges, spare opcodes
        send_op(OP_COUNT, '0, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_RESOLVE, 64'h1000, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_REGISTER, '0, 64'h100, KIND_IMAGE, 16'h1111);
        send_op(OP_REGISTER, 64'h1000, '0, KIND_IMAGE, 16'h2222);
        idle_gap();
        send_op(OP_REGISTER, 64'h1000, 64'h100, KIND_BUFFER, 16'h0000);
        send_op(OP_REGISTER, 64'h1080, 64'h100, KIND_IMAGE, 16'hFFFF);
        send_op(OP_RESOLVE, 64'h10C0, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_REGISTER, 64'h1000, 64'h40, KIND_GPU_HEAP, 16'h1234);
        send_op(OP_RESOLVE, 64'h1010, ADDR_MAX, KIND_BINDLESS, 16'hFFFF);
        idle_gap();
        send_op(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFF0, 64'h20, KIND_BINDLESS, 16'hA5A5);
        send_op(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_FFF8, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FF00, 64'hFF, KIND_BINDLESS, 16'h5A5A);
        send_op(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_FFFE, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_REGISTER, 64'h1, ADDR_MAX, KIND_IMAGE, 16'h00FF);
        send_op(OP_RESOLVE, 64'h8000_0000_0000_0000, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_UNREGISTER, 64'h5000, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_UNREG_RANGE, 64'hFFFF_FFFF_FFFF_FF00, 64'h200, KIND_BUFFER, 16'h0000);
        send_op(OP_UNREG_RANGE, 64'h1000, 64'h81, KIND_BUFFER, 16'h0000);
        send_op(OP_UNREGISTER, 64'hFFFF_FFFF_FFFF_FFF0, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_SPARE_6, ADDR_MAX, ADDR_MAX, KIND_BINDLESS, 16'hFFFF);
        send_op(OP_SPARE_7, '0, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_COUNT, '0, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_CLEAR, '0, '0, KIND_BUFFER, 16'h0000);
        send_op(OP_RESOLVE, 64'hFFFF_FFFF_FFFF_FF80, '0, KIND_BUFFER, 16'h0000);

        // Random part in phases; every third phase fills the table toward full
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                fill_phase = ((n / PHASE_LEN) % 3) == 0;
                idle_on    = $urandom_range(0, 3) != 0;
            end
            op = pick_op(fill_phase);
            r  = $urandom_range(0, 9);
            case (op)
                OP_REGISTER: begin
                    addr = ($urandom_range(0, 99) < 3) ? '0 : pick_start();
                    size = pick_size();
                end
                OP_UNREGISTER: begin
                    addr = (r < 7) ? recent_start() : pick_start();
                    size = rand_wide();
                end
                OP_UNREG_RANGE: begin
                    addr = (r < 5) ? recent_start() : pick_start();
                    size = (r < 8) ? ADDR_W'($urandom_range(1, 4096)) : rand_wide();
                end
                OP_RESOLVE: begin
                    if (r < 6)
                        addr = recent_start() + ADDR_W'($urandom_range(0, 300));
                    else if (r < 9)
                        addr = pick_start();
                    else
                        addr = rand_wide();
                    size = rand_wide();
                end
                default: begin
                    addr = rand_wide();
                    size = rand_wide();
                end
            endcase
            send_op(op, addr, size, KIND_W'($urandom_range(0, 3)),
                    TAG_W'($urandom_range(0, 65535)));
            if (idle_on)
                idle_gap();
        end

        // Drain, then give any stray result beat time to show up
        in_valid <= 1'b0;
        @(posedge clk);
        wait (results_owed == 0);
        repeat (2 * ENTRIES + 10) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("address_range_resolver_table_unit test passed");
        else
            $display("address_range_resolver_table_unit test failed");
        $finish;
    end

endmodule
